[rtl/core/erbr_pkg.sv]
`timescale 1ns / 1ps

package erbr_pkg;

    localparam int COEF_BITS = 21;
    localparam int COEF_FRAC = 10;
    localparam int VEC_FRAC  = 16;

    localparam int VEC_W   = 32;
    localparam int CFG_W   = 63;
    localparam int IDX_W   = 3;
    localparam int ROW_W   = 3 * COEF_BITS;

    localparam int PM_W    = COEF_BITS + VEC_W;
    localparam int MOM_W   = COEF_BITS + VEC_W + 2;
    localparam int LO_W    = 32;
    localparam int MOMH_W  = MOM_W - LO_W;
    localparam int S_W     = MOM_W + VEC_W + 2;
    localparam int SH_W    = S_W - 2 * LO_W;
    localparam int ACC_W   = COEF_BITS + S_W + 2;

    localparam int G_SHIFT   = COEF_FRAC + VEC_FRAC;
    localparam int OUT_SHIFT = 2 * COEF_FRAC + VEC_FRAC;

    localparam int NUM_STAGE = 9;
    localparam int LATENCY   = NUM_STAGE;

    localparam logic [IDX_W-1:0] REG_INERTIA_X = 3'd0;
    localparam logic [IDX_W-1:0] REG_INERTIA_Y = 3'd1;
    localparam logic [IDX_W-1:0] REG_INERTIA_Z = 3'd2;
    localparam logic [IDX_W-1:0] REG_INVERSE_X = 3'd3;
    localparam logic [IDX_W-1:0] REG_INVERSE_Y = 3'd4;
    localparam logic [IDX_W-1:0] REG_INVERSE_Z = 3'd5;

    localparam logic signed [VEC_W-1:0] SAT_MAX = 32'sh7fffffff;
    localparam logic signed [VEC_W-1:0] SAT_MIN = 32'sh80000000;

    localparam logic [1:0] CROSS_A [3] = '{2'd1, 2'd2, 2'd0};
    localparam logic [1:0] CROSS_B [3] = '{2'd2, 2'd0, 2'd1};

    typedef struct packed {
        logic signed [VEC_W-1:0] rate_x;
        logic signed [VEC_W-1:0] rate_y;
        logic signed [VEC_W-1:0] rate_z;
        logic signed [VEC_W-1:0] torque_x;
        logic signed [VEC_W-1:0] torque_y;
        logic signed [VEC_W-1:0] torque_z;
    } t_in;

    typedef struct packed {
        logic signed [VEC_W-1:0] accel_x;
        logic signed [VEC_W-1:0] accel_y;
        logic signed [VEC_W-1:0] accel_z;
        logic                    saturated;
    } t_out;

    function automatic logic signed [COEF_BITS-1:0] coef(
        input logic [ROW_W-1:0] row,
        input logic [1:0]       col
    );
        return row[col*COEF_BITS +: COEF_BITS];
    endfunction

endpackage

[rtl/core/euler_rigid_body_rate.sv]
`timescale 1ns / 1ps

// angular rate derivative dw/dt = Iinv * (g + (I*w) x w), one transaction per
// clock: busy never rises, so start may be held high every cycle. each result
// is on o_out with o_valid for one cycle, after the nine register stages of the
// multiply and add pipeline; the receiver cannot stall and must take it then.
// matrix rows are written through the cfg port (always ready); the user must
// write them only while no transaction is in flight; the block does not enforce it.
module euler_rigid_body_rate (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  erbr_pkg::t_in            i_in,
    output logic                     o_valid,
    output erbr_pkg::t_out           o_out,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [erbr_pkg::IDX_W-1:0] i_cfg_index,
    input  logic [erbr_pkg::CFG_W-1:0] i_cfg_data
);
    import erbr_pkg::*;

    logic [ROW_W-1:0] r_inertia [3];
    logic [ROW_W-1:0] r_inverse [3];

    logic [NUM_STAGE-1:0] r_vld;

    logic signed [VEC_W-1:0] n_w [3];
    logic signed [VEC_W-1:0] n_g [3];

    logic signed [PM_W-1:0]  n1_prod [3][3];
    logic signed [PM_W-1:0]  r1_prod [3][3];
    logic signed [VEC_W-1:0] r1_w [3];
    logic signed [VEC_W-1:0] r1_g [3];

    logic signed [MOM_W-1:0] n2_mom [3];
    logic signed [MOM_W-1:0] r2_mom [3];
    logic signed [VEC_W-1:0] r2_w [3];
    logic signed [VEC_W-1:0] r2_g [3];

    logic signed [LO_W+VEC_W:0]     n3_plo [3];
    logic signed [LO_W+VEC_W:0]     n3_qlo [3];
    logic signed [MOMH_W+VEC_W-1:0] n3_phi [3];
    logic signed [MOMH_W+VEC_W-1:0] n3_qhi [3];
    logic signed [LO_W+VEC_W:0]     r3_plo [3];
    logic signed [LO_W+VEC_W:0]     r3_qlo [3];
    logic signed [MOMH_W+VEC_W-1:0] r3_phi [3];
    logic signed [MOMH_W+VEC_W-1:0] r3_qhi [3];
    logic signed [VEC_W-1:0]        r3_g [3];

    logic signed [S_W-1:0] n4_p [3];
    logic signed [S_W-1:0] n4_q [3];
    logic signed [S_W-1:0] n4_g [3];
    logic signed [S_W-1:0] r4_p [3];
    logic signed [S_W-1:0] r4_q [3];
    logic signed [S_W-1:0] r4_g [3];

    logic signed [S_W-1:0] n5_s [3];
    logic signed [S_W-1:0] r5_s [3];

    logic signed [COEF_BITS+LO_W:0]  n6_m0 [3][3];
    logic signed [COEF_BITS+LO_W:0]  n6_m1 [3][3];
    logic signed [COEF_BITS+SH_W-1:0] n6_m2 [3][3];
    logic signed [COEF_BITS+LO_W:0]  r6_m0 [3][3];
    logic signed [COEF_BITS+LO_W:0]  r6_m1 [3][3];
    logic signed [COEF_BITS+SH_W-1:0] r6_m2 [3][3];

    logic signed [ACC_W-1:0] n7_prod [3][3];
    logic signed [ACC_W-1:0] r7_prod [3][3];

    logic signed [ACC_W-1:0] n8_acc [3];
    logic signed [ACC_W-1:0] r8_acc [3];

    logic signed [ACC_W-1:0] n9_shr [3];
    logic signed [VEC_W-1:0] n9_val [3];
    logic [2:0]              n9_clip;
    t_out                    n_out;
    t_out                    r_out;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_vld[NUM_STAGE-1];
    assign o_out       = r_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_inertia[i] <= '0;
                r_inverse[i] <= '0;
            end
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_INERTIA_X: r_inertia[0] <= i_cfg_data[ROW_W-1:0];
                REG_INERTIA_Y: r_inertia[1] <= i_cfg_data[ROW_W-1:0];
                REG_INERTIA_Z: r_inertia[2] <= i_cfg_data[ROW_W-1:0];
                REG_INVERSE_X: r_inverse[0] <= i_cfg_data[ROW_W-1:0];
                REG_INVERSE_Y: r_inverse[1] <= i_cfg_data[ROW_W-1:0];
                REG_INVERSE_Z: r_inverse[2] <= i_cfg_data[ROW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[NUM_STAGE-2:0], start & ~busy};
        end
    end

    // stage 1: inertia products
    always_comb begin
        n_w[0] = i_in.rate_x;
        n_w[1] = i_in.rate_y;
        n_w[2] = i_in.rate_z;
        n_g[0] = i_in.torque_x;
        n_g[1] = i_in.torque_y;
        n_g[2] = i_in.torque_z;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n1_prod[i][j] = coef(r_inertia[i], 2'(j)) * n_w[j];
            end
        end
    end

    // stage 2: angular momentum
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n2_mom[i] = MOM_W'(r1_prod[i][0]) + MOM_W'(r1_prod[i][1])
                      + MOM_W'(r1_prod[i][2]);
        end
    end

    // stage 3: cross product partial products
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n3_plo[i] = $signed({1'b0, r2_mom[CROSS_A[i]][LO_W-1:0]}) * r2_w[CROSS_B[i]];
            n3_phi[i] = $signed(r2_mom[CROSS_A[i]][MOM_W-1:LO_W]) * r2_w[CROSS_B[i]];
            n3_qlo[i] = $signed({1'b0, r2_mom[CROSS_B[i]][LO_W-1:0]}) * r2_w[CROSS_A[i]];
            n3_qhi[i] = $signed(r2_mom[CROSS_B[i]][MOM_W-1:LO_W]) * r2_w[CROSS_A[i]];
        end
    end

    // stage 4: recombine partial products, align torque
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n4_p[i] = (S_W'(r3_phi[i]) <<< LO_W) + S_W'(r3_plo[i]);
            n4_q[i] = (S_W'(r3_qhi[i]) <<< LO_W) + S_W'(r3_qlo[i]);
            n4_g[i] = S_W'(r3_g[i]) <<< G_SHIFT;
        end
    end

    // stage 5: torque plus gyroscopic term
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n5_s[i] = r4_p[i] - r4_q[i] + r4_g[i];
        end
    end

    // stage 6: inverse inertia partial products
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n6_m0[i][j] = coef(r_inverse[i], 2'(j))
                            * $signed({1'b0, r5_s[j][LO_W-1:0]});
                n6_m1[i][j] = coef(r_inverse[i], 2'(j))
                            * $signed({1'b0, r5_s[j][2*LO_W-1:LO_W]});
                n6_m2[i][j] = coef(r_inverse[i], 2'(j))
                            * $signed(r5_s[j][S_W-1:2*LO_W]);
            end
        end
    end

    // stage 7: recombine
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n7_prod[i][j] = (ACC_W'(r6_m2[i][j]) <<< (2 * LO_W))
                              + (ACC_W'(r6_m1[i][j]) <<< LO_W)
                              + ACC_W'(r6_m0[i][j]);
            end
        end
    end

    // stage 8: row sums
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n8_acc[i] = r7_prod[i][0] + r7_prod[i][1] + r7_prod[i][2];
        end
    end

    // stage 9: floor and saturate
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n9_shr[i] = r8_acc[i] >>> OUT_SHIFT;
            if ((n9_shr[i][ACC_W-1:VEC_W-1] == '0) || (n9_shr[i][ACC_W-1:VEC_W-1] == '1)) begin
                n9_val[i]  = n9_shr[i][VEC_W-1:0];
                n9_clip[i] = 1'b0;
            end else begin
                n9_val[i]  = n9_shr[i][ACC_W-1] ? SAT_MIN : SAT_MAX;
                n9_clip[i] = 1'b1;
            end
        end
        n_out.accel_x   = n9_val[0];
        n_out.accel_y   = n9_val[1];
        n_out.accel_z   = n9_val[2];
        n_out.saturated = |n9_clip;
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r1_prod <= n1_prod;
        r1_w    <= n_w;
        r1_g    <= n_g;
        r2_mom  <= n2_mom;
        r2_w    <= r1_w;
        r2_g    <= r1_g;
        r3_plo  <= n3_plo;
        r3_phi  <= n3_phi;
        r3_qlo  <= n3_qlo;
        r3_qhi  <= n3_qhi;
        r3_g    <= r2_g;
        r4_p    <= n4_p;
        r4_q    <= n4_q;
        r4_g    <= n4_g;
        r5_s    <= n5_s;
        r6_m0   <= n6_m0;
        r6_m1   <= n6_m1;
        r6_m2   <= n6_m2;
        r7_prod <= n7_prod;
        r8_acc  <= n8_acc;
        r_out   <= n_out;
    end

endmodule

[rtl/core/erbr_chk.sv]
`timescale 1ns / 1ps

module erbr_chk (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  logic           busy,
    input  logic           o_valid,
    input  erbr_pkg::t_out o_out,
    input  logic           o_cfg_ready
);
    import erbr_pkg::*;

    // every accepted transaction is followed by its result on o_valid
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_valid)
        else $error("accepted transaction produced no result");

    // no result without a matching accepted transaction before it
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LATENCY))
        else $error("result without accepted transaction");

    // the flag is only raised on a clipped component
    a_sat_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out.saturated) |->
            (o_out.accel_x == SAT_MAX || o_out.accel_x == SAT_MIN ||
             o_out.accel_y == SAT_MAX || o_out.accel_y == SAT_MIN ||
             o_out.accel_z == SAT_MAX || o_out.accel_z == SAT_MIN))
        else $error("saturation flag without clipped component");

    // pipeline never holds off input or configuration
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy && o_cfg_ready)
        else $error("block not ready");

endmodule

bind euler_rigid_body_rate erbr_chk u_erbr_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_valid     (o_valid),
    .o_out       (o_out),
    .o_cfg_ready (o_cfg_ready)
);

[dv/tb_euler_rigid_body_rate.sv]
`timescale 1ns / 1ps

module tb_euler_rigid_body_rate;
    import erbr_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam logic [IDX_W-1:0] REG_UNUSED_A = 3'd6;
    localparam logic [IDX_W-1:0] REG_UNUSED_B = 3'd7;
    localparam logic [COEF_BITS-1:0] COEF_MAXV = 21'h0fffff;
    localparam logic [COEF_BITS-1:0] COEF_MINV = 21'h100000;
    localparam logic [COEF_BITS-1:0] COEF_UNIT = 21'd1 << COEF_FRAC;
    localparam logic signed [VEC_W-1:0] MAXV = 32'sh7fffffff;
    localparam logic signed [VEC_W-1:0] MINV = 32'sh80000000;
    localparam logic signed [VEC_W-1:0] ONE  = 32'sh00010000;

    typedef enum int {CFG_FULL, CFG_SMALL, CFG_DIAG, CFG_EXTREME} cfg_mode_e;

    class accel_scoreboard;
        typedef logic signed [127:0] wide_t;
        localparam wide_t SAT_HI = 128'sh7fffffff;
        localparam wide_t SAT_LO = -128'sh80000000;

        logic [CFG_W-1:0] rows [6];
        t_out accel_q [$];
        int errors;

        function new();
            foreach (rows[r]) rows[r] = '0;
            errors = 0;
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            if (idx <= REG_INVERSE_Z) rows[idx] = data;
        endfunction

        function wide_t coef_at(logic [CFG_W-1:0] row, int col);
            logic signed [COEF_BITS-1:0] c;
            c = row[col*COEF_BITS +: COEF_BITS];
            return c;
        endfunction

        function void predict_accel(t_in item);
            wide_t w [3];
            wide_t g [3];
            wide_t mom [3];
            wide_t s [3];
            wide_t acc;
            logic signed [VEC_W-1:0] comp [3];
            logic clip;
            t_out res;
            w = '{item.rate_x, item.rate_y, item.rate_z};
            g = '{item.torque_x, item.torque_y, item.torque_z};
            clip = 1'b0;
            for (int i = 0; i < 3; i++) begin
                mom[i] = '0;
                for (int j = 0; j < 3; j++) mom[i] += coef_at(rows[i], j) * w[j];
            end
            // angular momentum cross rate plus torque
            for (int i = 0; i < 3; i++) begin
                s[i] = mom[(i+1)%3] * w[(i+2)%3] - mom[(i+2)%3] * w[(i+1)%3]
                     + (g[i] <<< (COEF_FRAC + VEC_FRAC));
            end
            for (int i = 0; i < 3; i++) begin
                acc = '0;
                for (int j = 0; j < 3; j++) acc += coef_at(rows[3+i], j) * s[j];
                acc = acc >>> (2*COEF_FRAC + VEC_FRAC);
                if (acc > SAT_HI) begin
                    comp[i] = SAT_MAX;
                    clip = 1'b1;
                end else if (acc < SAT_LO) begin
                    comp[i] = SAT_MIN;
                    clip = 1'b1;
                end else begin
                    comp[i] = acc[VEC_W-1:0];
                end
            end
            res.accel_x = comp[0];
            res.accel_y = comp[1];
            res.accel_z = comp[2];
            res.saturated = clip;
            accel_q.push_back(res);
        endfunction

        task report(string what);
            errors++;
            $display("mismatch at %0t: %s", $time, what);
        endtask

        task check_accel(t_out got);
            t_out want;
            if (accel_q.size() == 0) begin
                report("result with no transaction outstanding");
                return;
            end
            want = accel_q.pop_front();
            if (got.accel_x !== want.accel_x)
                report($sformatf("accel_x got %h want %h", got.accel_x, want.accel_x));
            if (got.accel_y !== want.accel_y)
                report($sformatf("accel_y got %h want %h", got.accel_y, want.accel_y));
            if (got.accel_z !== want.accel_z)
                report($sformatf("accel_z got %h want %h", got.accel_z, want.accel_z));
            if (got.saturated !== want.saturated)
                report($sformatf("saturated got %b want %b", got.saturated, want.saturated));
        endtask

        function int pending();
            return accel_q.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_in i_in;
    logic o_valid;
    t_out o_out;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0] i_cfg_data;

    accel_scoreboard sb = new();
    int idle_pct;
    int unsigned cycles;

    euler_rigid_body_rate dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_in(i_in),
        .o_valid(o_valid),
        .o_out(o_out),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) sb.check_accel(o_out);
    end

    function automatic logic signed [VEC_W-1:0] rand_comp();
        case ($urandom_range(7))
            0, 1: return $urandom;
            2: return MAXV;
            3: return MINV;
            4: return int'($urandom_range(0, 32'h800)) - 32'h400;
            default: return int'($urandom_range(0, 32'h80000)) - 32'h40000;
        endcase
    endfunction

    function automatic t_in rand_item();
        return t_in'{rand_comp(), rand_comp(), rand_comp(),
                     rand_comp(), rand_comp(), rand_comp()};
    endfunction

    function automatic logic [CFG_W-1:0] diag_row(int col, logic [COEF_BITS-1:0] c);
        logic [CFG_W-1:0] row;
        row = '0;
        row[col*COEF_BITS +: COEF_BITS] = c;
        return row;
    endfunction

    function automatic logic [CFG_W-1:0] make_row(cfg_mode_e mode, int diag);
        logic [CFG_W-1:0] row;
        logic [COEF_BITS-1:0] c;
        row = '0;
        for (int j = 0; j < 3; j++) begin
            case (mode)
                CFG_FULL: c = COEF_BITS'($urandom);
                CFG_SMALL: c = COEF_BITS'(int'($urandom_range(0, 4096)) - 2048);
                CFG_DIAG: c = (j == diag) ? COEF_BITS'($urandom_range(256, 8192))
                                          : COEF_BITS'(int'($urandom_range(0, 128)) - 64);
                default: begin
                    case ($urandom_range(3))
                        0: c = COEF_MAXV;
                        1: c = COEF_MINV;
                        2: c = '0;
                        default: c = '1;
                    endcase
                end
            endcase
            row[j*COEF_BITS +: COEF_BITS] = c;
        end
        return row;
    endfunction

    task automatic drive_item(input t_in item);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_in <= item;
        do @(posedge i_clk); while (busy);
        sb.predict_accel(item);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
    endtask

    task automatic load_matrices(input logic [CFG_W-1:0] rows [6], input bit with_unused);
        logic [IDX_W-1:0] idx [6];
        idx = '{REG_INERTIA_X, REG_INERTIA_Y, REG_INERTIA_Z,
                REG_INVERSE_X, REG_INVERSE_Y, REG_INVERSE_Z};
        // writes to unused indexes must leave the matrices alone
        if (with_unused) put_reg(REG_UNUSED_A, CFG_W'({$urandom, $urandom}));
        for (int k = 0; k < 6; k++) put_reg(idx[k], rows[k]);
        if (with_unused) put_reg(REG_UNUSED_B, CFG_W'({$urandom, $urandom}));
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_random(input cfg_mode_e mode);
        logic [CFG_W-1:0] rows [6];
        for (int r = 0; r < 6; r++) rows[r] = make_row(mode, r % 3);
        load_matrices(rows, $urandom_range(1) == 1);
    endtask

    initial begin
        logic [CFG_W-1:0] rows [6];
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_in <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        idle_pct = 9;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero matrices after reset
        drive_item(t_in'{MAXV, MAXV, MAXV, MAXV, MAXV, MAXV});
        drive_item(t_in'{MINV, MINV, MINV, MINV, MINV, MINV});
        drive_item(t_in'{ONE, -ONE, ONE, -ONE, ONE, -ONE});
        drive_item(rand_item());
        drain();

        // unit matrices, cross term vanishes
        rows = '{diag_row(0, COEF_UNIT), diag_row(1, COEF_UNIT), diag_row(2, COEF_UNIT),
                 diag_row(0, COEF_UNIT), diag_row(1, COEF_UNIT), diag_row(2, COEF_UNIT)};
        load_matrices(rows, 1'b1);
        drive_item(t_in'{32'sd0, 32'sd0, 32'sd0, MAXV, MINV, ONE});
        drive_item(t_in'{MAXV, MINV, ONE, 32'sd0, 32'sd0, 32'sd0});
        drive_item(t_in'{ONE, 2*ONE, 3*ONE, -ONE, 32'sd0, ONE});
        drive_item(t_in'{MINV, MINV, MINV, MINV, MINV, MINV});
        drive_item(t_in'{MAXV, MAXV, MAXV, MAXV, MAXV, MAXV});
        drain();

        // unequal principal moments
        rows = '{diag_row(0, COEF_UNIT), diag_row(1, COEF_UNIT << 1),
                 diag_row(2, COEF_UNIT << 2), diag_row(0, COEF_UNIT),
                 diag_row(1, COEF_UNIT >> 1), diag_row(2, COEF_UNIT >> 2)};
        load_matrices(rows, 1'b0);
        drive_item(t_in'{ONE, ONE, ONE, 32'sd0, 32'sd0, 32'sd0});
        drive_item(t_in'{MAXV, MAXV, MINV, 32'sd0, 32'sd0, 32'sd0});
        drive_item(t_in'{-ONE, 2*ONE, -3*ONE, ONE, ONE, ONE});
        drive_item(t_in'{MAXV, MINV, MAXV, MINV, MAXV, MINV});
        drain();

        // extreme coefficients
        rows = '{6{{3{COEF_MAXV}}}};
        load_matrices(rows, 1'b0);
        drive_item(t_in'{MAXV, MAXV, MAXV, MAXV, MAXV, MAXV});
        drive_item(t_in'{MINV, MINV, MINV, MINV, MINV, MINV});
        drive_item(t_in'{ONE, -ONE, 32'sd1, -32'sd1, ONE, MINV});
        drain();
        rows = '{6{{3{COEF_MINV}}}};
        load_matrices(rows, 1'b0);
        drive_item(t_in'{MINV, MINV, MINV, MINV, MINV, MINV});
        drive_item(t_in'{MAXV, MINV, MAXV, MINV, MAXV, MINV});
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            idle_pct = (ph == 0) ? 9 : (ph == 1) ? 81 : 0;
            for (int seg = 0; seg < 4; seg++) begin
                load_random(cfg_mode_e'((seg + ph) % 4));
                repeat (78) drive_item(rand_item());
                drain();
            end
        end

        repeat (2 * LATENCY) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
